### design/background_tile_pixel_fetch_defines.svh
// ----------------------------------------------------------------------------
// background_tile_pixel_fetch_defines : assertion macros
// Concurrent check macros on i_clk; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BACKGROUND_TILE_PIXEL_FETCH_DEFINES_SVH
`define BACKGROUND_TILE_PIXEL_FETCH_DEFINES_SVH

`ifndef SYNTHESIS
// check outside reset
`define BTPF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("btpf check failed");
// check that also runs through reset
`define BTPF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("btpf check failed");
`else
`define BTPF_ASSERT(lbl, prop)
`define BTPF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### design/btpf_pkg.sv
// ----------------------------------------------------------------------------
// btpf_pkg : shared types and constants
// Widths, address map pieces, register indexes and controller commands.
// ----------------------------------------------------------------------------
package btpf_pkg;

    localparam int STORE_DEPTH = 16384;
    localparam int ADDR_W      = 14;
    localparam int DATA_W      = 8;
    localparam int CFG_IDX_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NAMETABLE_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SELECT   = 2'd1;

    // address map fragments
    localparam logic [1:0] NT_ROOT   = 2'b10;     // 0x2000
    localparam logic [3:0] ATTR_ROOT = 4'b1111;   // 0x3C0 within a nametable
    localparam logic [5:0] PAL_ROOT  = 6'b111111; // 0x3F00
    localparam logic [3:0] PAL_GAP   = 4'b0000;

    typedef enum logic [2:0] {
        A_INPUT,
        A_NT,
        A_AT,
        A_PL,
        A_PH,
        A_PAL
    } t_addr_sel;

    typedef enum logic [2:0] {
        C_NONE,
        C_NT,
        C_AT,
        C_PL,
        C_PH,
        C_PAL
    } t_cap_sel;

    typedef struct packed {
        logic      ram_we;
        t_addr_sel addr_sel;
        logic [1:0] rd_pal;
        t_cap_sel  cap;
        logic [1:0] cap_pal;
        logic      latch_pixel;
        logic      load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_render;
        logic fetch_needed;
    } t_dp_status;

endpackage

### design/background_tile_pixel_fetch.sv
// ----------------------------------------------------------------------------
// background_tile_pixel_fetch : background tile pixel generator
// Tile/attribute/pattern/palette fetch over a 16 KB video store.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_in_valid / o_in_ready): one beat is either a store write
//  (i_mode 0: i_write_data to i_vram_address) or a pixel render (i_mode 1:
//  i_pixel_x, i_pixel_y, i_force_fetch).
//  Output channel (o_out_valid / i_out_ready): one colour beat per render;
//  writes give nothing.
//  Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is
//  nametable select, index 1 pattern select; other indexes are ignored.
//  Write it only while the block is idle.
//  Sequence: a write is done when accepted; a render without fetch goes
//  straight to the result load. A render that fetches (x multiple of 8 or
//  forced) issues eight reads in turn on the single store port (patterns need
//  the tile byte, palettes the attribute byte), then capture and result load.
//  Result register: the next beat is taken while a colour waits; a render
//  whose colour is ready waits in its last step while the receiver stalls.
//  Reset (i_rst_n low, synchronous) clears the controller, the tile cache and
//  the config registers; store contents are undefined until written.
// ----------------------------------------------------------------------------
module background_tile_pixel_fetch import btpf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config port
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // input beats
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic [ADDR_W-1:0]    i_vram_address,
    input  logic [DATA_W-1:0]    i_write_data,
    input  logic [7:0]           i_pixel_x,
    input  logic [7:0]           i_pixel_y,
    input  logic                 i_force_fetch,
    // result beats
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DATA_W-1:0]    o_colour
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // config writes never stall
    assign o_cfg_ready = 1'b1;

    btpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    btpf_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_vram_address (i_vram_address),
        .i_write_data   (i_write_data),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_force_fetch  (i_force_fetch),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_colour       (o_colour)
    );

endmodule

### design/btpf_ram.sv
// ----------------------------------------------------------------------------
// btpf_ram : generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module btpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/btpf_ctrl.sv
// ----------------------------------------------------------------------------
// btpf_ctrl : sequencing controller
// Accepts beats, steps the tile fetch reads and manages the result register.
// ----------------------------------------------------------------------------
`include "background_tile_pixel_fetch_defines.svh"

module btpf_ctrl import btpf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NT,
        S_AT,
        S_PL,
        S_PH,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_PCAP,
        S_EMIT
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    in_acc;
    logic    out_free;
    t_dp_cmd cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state          = r_state;
        n_out_valid      = r_out_valid && !i_out_ready;
        cmd.ram_we       = 1'b0;
        cmd.addr_sel     = A_INPUT;
        cmd.rd_pal       = 2'd0;
        cmd.cap          = C_NONE;
        cmd.cap_pal      = 2'd0;
        cmd.latch_pixel  = 1'b0;
        cmd.load_out     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                cmd.ram_we      = in_acc && !i_status.is_render;
                cmd.latch_pixel = in_acc && i_status.is_render;
                if (in_acc && i_status.is_render) begin
                    n_state = i_status.fetch_needed ? S_NT : S_EMIT;
                end
            end
            S_NT: begin
                cmd.addr_sel = A_NT;
                n_state      = S_AT;
            end
            S_AT: begin
                cmd.addr_sel = A_AT;
                cmd.cap      = C_NT;
                n_state      = S_PL;
            end
            S_PL: begin
                cmd.addr_sel = A_PL;
                cmd.cap      = C_AT;
                n_state      = S_PH;
            end
            S_PH: begin
                cmd.addr_sel = A_PH;
                cmd.cap      = C_PL;
                n_state      = S_P0;
            end
            S_P0: begin
                cmd.addr_sel = A_PAL;
                cmd.rd_pal   = 2'd0;
                cmd.cap      = C_PH;
                n_state      = S_P1;
            end
            S_P1: begin
                cmd.addr_sel = A_PAL;
                cmd.rd_pal   = 2'd1;
                cmd.cap      = C_PAL;
                cmd.cap_pal  = 2'd0;
                n_state      = S_P2;
            end
            S_P2: begin
                cmd.addr_sel = A_PAL;
                cmd.rd_pal   = 2'd2;
                cmd.cap      = C_PAL;
                cmd.cap_pal  = 2'd1;
                n_state      = S_P3;
            end
            S_P3: begin
                cmd.addr_sel = A_PAL;
                cmd.rd_pal   = 2'd3;
                cmd.cap      = C_PAL;
                cmd.cap_pal  = 2'd2;
                n_state      = S_PCAP;
            end
            S_PCAP: begin
                cmd.cap     = C_PAL;
                cmd.cap_pal = 2'd3;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `BTPF_ASSERT(a_fetch_starts, in_acc && i_status.is_render && i_status.fetch_needed |=> r_state == S_NT)
    `BTPF_ASSERT(a_emit_loads, r_state == S_EMIT && out_free |=> r_state == S_IDLE && r_out_valid)
    `BTPF_ASSERT(a_result_drops_taken, $fell(r_out_valid) |-> $past(i_out_ready) || !$past(i_rst_n))
    `BTPF_ASSERT_ALWAYS(a_reset_idle, !$past(i_rst_n) |-> r_state == S_IDLE && !r_out_valid)

endmodule

### design/btpf_datapath.sv
// ----------------------------------------------------------------------------
// btpf_datapath : store, tile cache and pixel colour datapath
// Address generation, video store, cached tile bytes and the result register.
// ----------------------------------------------------------------------------
module btpf_datapath import btpf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_mode,
    input  logic [ADDR_W-1:0]    i_vram_address,
    input  logic [DATA_W-1:0]    i_write_data,
    input  logic [7:0]           i_pixel_x,
    input  logic [7:0]           i_pixel_y,
    input  logic                 i_force_fetch,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic [DATA_W-1:0]    o_colour
);

    logic [1:0]        r_nt_sel;
    logic              r_pat_sel;
    logic [7:0]        r_x, r_y;
    logic [DATA_W-1:0] r_nametable, r_attribute, r_pat_lo, r_pat_hi;
    logic [DATA_W-1:0] r_palette [4];
    logic [DATA_W-1:0] r_colour;

    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_rdata;
    logic [1:0]        quad_pal;
    logic [2:0]        bit_idx;
    logic [1:0]        pix_sel;

    assign o_status.is_render    = i_mode;
    assign o_status.fetch_needed = (i_pixel_x[2:0] == 3'd0) || i_force_fetch;

    // attribute quadrant: right by x bit 4, bottom by y bit 4
    always_comb begin
        case ({r_y[4], r_x[4]})
            2'b00:   quad_pal = r_attribute[1:0];
            2'b01:   quad_pal = r_attribute[3:2];
            2'b10:   quad_pal = r_attribute[5:4];
            default: quad_pal = r_attribute[7:6];
        endcase
    end

    always_comb begin
        case (i_cmd.addr_sel)
            A_NT:    ram_addr = {NT_ROOT, r_nt_sel, r_y[7:3], r_x[7:3]};
            A_AT:    ram_addr = {NT_ROOT, r_nt_sel, ATTR_ROOT, r_y[7:5], r_x[7:5]};
            A_PL:    ram_addr = {1'b0, r_pat_sel, r_nametable, 1'b0, r_y[2:0]};
            A_PH:    ram_addr = {1'b0, r_pat_sel, r_nametable, 1'b1, r_y[2:0]};
            A_PAL:   ram_addr = {PAL_ROOT, PAL_GAP, quad_pal, i_cmd.rd_pal};
            default: ram_addr = i_vram_address;
        endcase
    end

    btpf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_write_data),
        .o_rdata (ram_rdata)
    );

    assign bit_idx = 3'd7 - r_x[2:0];
    assign pix_sel = {r_pat_hi[bit_idx], r_pat_lo[bit_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nt_sel    <= 2'd0;
            r_pat_sel   <= 1'b0;
            r_nametable <= '0;
            r_attribute <= '0;
            r_pat_lo    <= '0;
            r_pat_hi    <= '0;
            for (int i = 0; i < 4; i++) begin
                r_palette[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NAMETABLE_SELECT: r_nt_sel  <= i_cfg_data[1:0];
                    CFG_PATTERN_SELECT:   r_pat_sel <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (i_cmd.cap)
                C_NT:    r_nametable <= ram_rdata;
                C_AT:    r_attribute <= ram_rdata;
                C_PL:    r_pat_lo    <= ram_rdata;
                C_PH:    r_pat_hi    <= ram_rdata;
                C_PAL:   r_palette[i_cmd.cap_pal] <= ram_rdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_pixel) begin
            r_x <= i_pixel_x;
            r_y <= i_pixel_y;
        end
        if (i_cmd.load_out) begin
            r_colour <= r_palette[pix_sel];
        end
    end

    assign o_colour = r_colour;

endmodule
